### src/lprd_pkg.sv
// shared types and constants of the length prefixed request deframer
`default_nettype none
package lprd_pkg;

  localparam int unsigned HdrBytes    = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned InDepthDef  = 2;
  localparam int unsigned OutDepthDef = 4;

  localparam logic [CfgIdxW-1:0] CfgMaxMsgLen   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxArgCount = CfgIdxW'(1);

  localparam logic [31:0] MaxMsgLenReset   = 32'd4096;
  localparam logic [15:0] MaxArgCountReset = 16'd1024;

  typedef enum logic [0:0] {
    KIND_DATA,
    KIND_RESTART
  } kind_e;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_COUNT,
    PH_ARGLEN,
    PH_DATA,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_LONG,
    ST_MALFORMED,
    ST_HALTED
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [15:0] arg_index;
    logic        arg_start;
    logic [31:0] arg_length;
    logic        arg_last_byte;
    logic        count_ready;
    logic [15:0] arg_count;
    logic        msg_done;
    status_e     status;
  } result_t;

endpackage
`default_nettype wire

### src/length_prefixed_request_deframer.sv
// top level of the length prefixed request deframer
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------
//  input    | push / full       | stream_byte_i, new_connection_i
//  result   | pop / empty       | data_valid_o .. status_o, one word per input
//  config   | cfg_we_i          | cfg_index_i, cfg_wdata_i (no wait, no read)
//
// one input word in and one result word out per cycle when neither side stalls;
// an accepted word is stored in the input queue, and its result in the result
// queue, whose head drives the result ports (the parser reads the input queue
// and writes the result queue in the same cycle). the parser advances only when
// the input queue holds a word and the result queue has room, so a stalled
// reader fills the result queue and then the input queue before full rises.
// reset clears the parser state and both queues and loads the default limits.
`default_nettype none
module length_prefixed_request_deframer #(
  parameter int unsigned InDepth  = lprd_pkg::InDepthDef,
  parameter int unsigned OutDepth = lprd_pkg::OutDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [7:0]                   stream_byte_i,
  input  wire logic                         new_connection_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              data_valid_o,
  output logic [7:0]                        data_byte_o,
  output logic [15:0]                       arg_index_o,
  output logic                              arg_start_o,
  output logic [31:0]                       arg_length_o,
  output logic                              arg_last_byte_o,
  output logic                              count_ready_o,
  output logic [15:0]                       arg_count_o,
  output logic                              msg_done_o,
  output logic [1:0]                        status_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [lprd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [lprd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [31:0] max_msg_len_q;
  logic [15:0] max_arg_count_q;

  lprd_pkg::in_item_t item;
  logic               item_empty, item_pop;
  logic               res_full, res_push;
  lprd_pkg::result_t  res_in, res_out;
  logic [$bits(lprd_pkg::result_t)-1:0] res_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_len_q   <= lprd_pkg::MaxMsgLenReset;
      max_arg_count_q <= lprd_pkg::MaxArgCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lprd_pkg::CfgMaxMsgLen:   max_msg_len_q   <= cfg_wdata_i[31:0];
        lprd_pkg::CfgMaxArgCount: max_arg_count_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  lprd_front #(
    .Depth (InDepth)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .stream_byte_i    (stream_byte_i),
    .new_connection_i (new_connection_i),
    .pop_i            (item_pop),
    .item_o           (item),
    .empty_o          (item_empty)
  );

  lprd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_msg_len_i   (max_msg_len_q),
    .max_arg_count_i (max_arg_count_q),
    .item_i          (item),
    .item_empty_i    (item_empty),
    .item_pop_o      (item_pop),
    .res_full_i      (res_full),
    .res_push_o      (res_push),
    .res_o           (res_in)
  );

  lprd_fifo #(
    .Width ($bits(lprd_pkg::result_t)),
    .Depth (OutDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out         = lprd_pkg::result_t'(res_rdata);
  assign data_valid_o    = res_out.data_valid;
  assign data_byte_o     = res_out.data_byte;
  assign arg_index_o     = res_out.arg_index;
  assign arg_start_o     = res_out.arg_start;
  assign arg_length_o    = res_out.arg_length;
  assign arg_last_byte_o = res_out.arg_last_byte;
  assign count_ready_o   = res_out.count_ready;
  assign arg_count_o     = res_out.arg_count;
  assign msg_done_o      = res_out.msg_done;
  assign status_o        = res_out.status;

endmodule
`default_nettype wire

### src/lprd_fifo.sv
// small first-in first-out queue with a count based full flag
`default_nettype none
module lprd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

### src/lprd_front.sv
// front end: takes stream words, classifies them and queues them for the parser
`default_nettype none
module lprd_front #(
  parameter int unsigned Depth = lprd_pkg::InDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              full_o,
  input  wire logic [7:0]   stream_byte_i,
  input  wire logic         new_connection_i,
  input  wire logic         pop_i,
  output lprd_pkg::in_item_t item_o,
  output logic              empty_o
);

  lprd_pkg::in_item_t item_in;
  logic [$bits(lprd_pkg::in_item_t)-1:0] rdata;

  // restart words carry no byte, keep it zero
  always_comb begin
    if (new_connection_i) begin
      item_in.kind = lprd_pkg::KIND_RESTART;
      item_in.data = 8'h00;
    end else begin
      item_in.kind = lprd_pkg::KIND_DATA;
      item_in.data = stream_byte_i;
    end
  end

  lprd_fifo #(
    .Width ($bits(lprd_pkg::in_item_t)),
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (item_in),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .rdata_o (rdata),
    .empty_o (empty_o)
  );

  assign item_o = lprd_pkg::in_item_t'(rdata);

endmodule
`default_nettype wire

### src/lprd_parser.sv
// back end: message parser FSM, one queued word per unstalled cycle
`default_nettype none
module lprd_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [31:0]        max_msg_len_i,
  input  wire logic [15:0]        max_arg_count_i,
  input  wire lprd_pkg::in_item_t item_i,
  input  wire logic               item_empty_i,
  output logic                    item_pop_o,
  input  wire logic               res_full_i,
  output logic                    res_push_o,
  output lprd_pkg::result_t       res_o
);

  lprd_pkg::phase_e phase_q, phase_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [31:0] hshift_q, hshift_d;
  logic [31:0] msg_left_q, msg_left_d;
  logic [15:0] args_left_q, args_left_d;
  logic [31:0] arg_left_q, arg_left_d;
  logic [15:0] cur_arg_q, cur_arg_d;
  logic [15:0] total_q, total_d;

  logic        step;
  logic [31:0] hdr_val;
  logic        hdr_done;
  logic        fail;
  lprd_pkg::status_e fail_code;
  logic        do_next;

  assign step       = !item_empty_i && !res_full_i;
  assign item_pop_o = step;
  assign res_push_o = step;

  assign hdr_val  = hshift_q | (32'(item_i.data) << {hcnt_q, 3'b000});
  assign hdr_done = (hcnt_q == 2'd3);

  always_comb begin
    phase_d     = phase_q;
    hcnt_d      = hcnt_q;
    hshift_d    = hshift_q;
    msg_left_d  = msg_left_q;
    args_left_d = args_left_q;
    arg_left_d  = arg_left_q;
    cur_arg_d   = cur_arg_q;
    total_d     = total_q;
    res_o       = '0;
    fail        = 1'b0;
    fail_code   = lprd_pkg::ST_OK;
    do_next     = 1'b0;

    if (item_i.kind == lprd_pkg::KIND_RESTART) begin
      phase_d     = lprd_pkg::PH_LEN;
      hcnt_d      = '0;
      hshift_d    = '0;
      msg_left_d  = '0;
      args_left_d = '0;
      arg_left_d  = '0;
      cur_arg_d   = '0;
      total_d     = '0;
    end else begin
      // header bytes are gathered in every header phase
      if (phase_q == lprd_pkg::PH_LEN || phase_q == lprd_pkg::PH_COUNT ||
          phase_q == lprd_pkg::PH_ARGLEN) begin
        if (hdr_done) begin
          hcnt_d   = '0;
          hshift_d = '0;
        end else begin
          hcnt_d   = hcnt_q + 2'd1;
          hshift_d = hdr_val;
        end
      end

      case (phase_q)
        lprd_pkg::PH_LEN: begin
          if (hdr_done) begin
            if (hdr_val > max_msg_len_i) begin
              fail      = 1'b1;
              fail_code = lprd_pkg::ST_TOO_LONG;
            end else if (hdr_val < 32'(lprd_pkg::HdrBytes)) begin
              fail      = 1'b1;
              fail_code = lprd_pkg::ST_MALFORMED;
            end else begin
              msg_left_d  = hdr_val;
              total_d     = '0;
              args_left_d = '0;
              cur_arg_d   = '0;
              phase_d     = lprd_pkg::PH_COUNT;
            end
          end
        end
        lprd_pkg::PH_COUNT: begin
          msg_left_d = msg_left_q - 32'd1;
          if (hdr_done) begin
            if (hdr_val > {16'h0000, max_arg_count_i}) begin
              fail      = 1'b1;
              fail_code = lprd_pkg::ST_MALFORMED;
            end else begin
              total_d           = hdr_val[15:0];
              args_left_d       = hdr_val[15:0];
              cur_arg_d         = '0;
              res_o.count_ready = 1'b1;
              do_next           = 1'b1;
            end
          end
        end
        lprd_pkg::PH_ARGLEN: begin
          msg_left_d = msg_left_q - 32'd1;
          if (hdr_done) begin
            if (hdr_val > msg_left_d) begin
              fail      = 1'b1;
              fail_code = lprd_pkg::ST_MALFORMED;
            end else begin
              res_o.arg_start  = 1'b1;
              res_o.arg_index  = cur_arg_q;
              res_o.arg_length = hdr_val;
              args_left_d      = args_left_q - 16'd1;
              if (hdr_val == '0) begin
                cur_arg_d = cur_arg_q + 16'd1;
                do_next   = 1'b1;
              end else begin
                arg_left_d = hdr_val;
                phase_d    = lprd_pkg::PH_DATA;
              end
            end
          end
        end
        lprd_pkg::PH_DATA: begin
          res_o.data_valid = 1'b1;
          res_o.data_byte  = item_i.data;
          res_o.arg_index  = cur_arg_q;
          msg_left_d       = msg_left_q - 32'd1;
          arg_left_d       = arg_left_q - 32'd1;
          if (arg_left_d == '0) begin
            res_o.arg_last_byte = 1'b1;
            cur_arg_d           = cur_arg_q + 16'd1;
            do_next             = 1'b1;
          end
        end
        default: begin
          phase_d      = lprd_pkg::PH_HALT;
          res_o.status = lprd_pkg::ST_HALTED;
        end
      endcase

      // decide what follows the count header or a finished argument
      if (do_next) begin
        if (args_left_d != '0) begin
          if (msg_left_d < 32'(lprd_pkg::HdrBytes)) begin
            fail      = 1'b1;
            fail_code = lprd_pkg::ST_MALFORMED;
          end else begin
            phase_d = lprd_pkg::PH_ARGLEN;
          end
        end else if (msg_left_d == '0) begin
          res_o.msg_done = 1'b1;
          phase_d        = lprd_pkg::PH_LEN;
        end else begin
          fail      = 1'b1;
          fail_code = lprd_pkg::ST_MALFORMED;
        end
      end

      if (fail) begin
        res_o        = '0;
        res_o.status = fail_code;
        phase_d      = lprd_pkg::PH_HALT;
      end

      if (res_o.status == lprd_pkg::ST_OK) begin
        res_o.arg_count = total_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lprd_pkg::PH_LEN;
      hcnt_q      <= '0;
      hshift_q    <= '0;
      msg_left_q  <= '0;
      args_left_q <= '0;
      arg_left_q  <= '0;
      cur_arg_q   <= '0;
      total_q     <= '0;
    end else if (step) begin
      phase_q     <= phase_d;
      hcnt_q      <= hcnt_d;
      hshift_q    <= hshift_d;
      msg_left_q  <= msg_left_d;
      args_left_q <= args_left_d;
      arg_left_q  <= arg_left_d;
      cur_arg_q   <= cur_arg_d;
      total_q     <= total_d;
    end
  end

endmodule
`default_nettype wire

### bench/length_prefixed_request_deframer_tb.sv
// self-checking testbench for the length prefixed request deframer
module length_prefixed_request_deframer_tb;
  import lprd_pkg::*;

  localparam int StallLimit = 2000;
  localparam logic [CfgIdxW-1:0] CfgUnusedA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgUnusedB = CfgIdxW'(3);

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_TOO_LONG,
    SHAPE_SHORT_BODY,
    SHAPE_TOO_MANY_ARGS,
    SHAPE_TRUNCATED_BODY,
    SHAPE_PADDED_BODY,
    SHAPE_OVERSIZE_ARG,
    SHAPE_CUT_SHORT
  } msg_shape_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          stream_byte_i = '0;
  logic                new_connection_i = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic                data_valid_o;
  logic [7:0]          data_byte_o;
  logic [15:0]         arg_index_o;
  logic                arg_start_o;
  logic [31:0]         arg_length_o;
  logic                arg_last_byte_o;
  logic                count_ready_o;
  logic [15:0]         arg_count_o;
  logic                msg_done_o;
  logic [1:0]          status_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  length_prefixed_request_deframer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .stream_byte_i    (stream_byte_i),
    .new_connection_i (new_connection_i),
    .empty            (empty),
    .pop              (pop),
    .data_valid_o     (data_valid_o),
    .data_byte_o      (data_byte_o),
    .arg_index_o      (arg_index_o),
    .arg_start_o      (arg_start_o),
    .arg_length_o     (arg_length_o),
    .arg_last_byte_o  (arg_last_byte_o),
    .count_ready_o    (count_ready_o),
    .arg_count_o      (arg_count_o),
    .msg_done_o       (msg_done_o),
    .status_o         (status_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // parser state mirror and limits
  phase_e      p_phase;
  logic [1:0]  p_hdr_cnt;
  logic [31:0] p_hdr_acc;
  logic [31:0] p_body_left;
  logic [15:0] p_args_left;
  logic [31:0] p_arg_left;
  logic [15:0] p_arg_idx;
  logic [15:0] p_arg_total;
  logic [31:0] lim_msg_len;
  logic [15:0] lim_arg_cnt;

  in_item_t    stream_words[$];
  result_t     parsed_due[$];
  logic [7:0]  msg_bytes[$];
  in_item_t    cur_word;
  int          stim_count = 0;
  int          results_seen = 0;
  int          error_count = 0;
  int          stall_cycles = 0;
  int          send_wait = 0;
  int          recv_wait = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;
  logic        reader_hold = 1'b0;

  function automatic void clear_parse_state();
    p_phase     = PH_LEN;
    p_hdr_cnt   = '0;
    p_hdr_acc   = '0;
    p_body_left = '0;
    p_args_left = '0;
    p_arg_left  = '0;
    p_arg_idx   = '0;
    p_arg_total = '0;
  endfunction

  // little-endian header assembly, true once the fourth byte is in
  function automatic logic shift_header(input logic [7:0] b, output logic [31:0] v);
    p_hdr_acc = p_hdr_acc | ({24'd0, b} << (8 * p_hdr_cnt));
    v = p_hdr_acc;
    if (p_hdr_cnt == 2'd3) begin
      p_hdr_acc = '0;
      p_hdr_cnt = '0;
      return 1'b1;
    end
    p_hdr_cnt = p_hdr_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic void halt_with(inout result_t r, input status_e code);
    r = '0;
    r.status = code;
    p_phase = PH_HALT;
  endfunction

  // after the count header or an argument: next header, message end, or error
  function automatic void close_item(inout result_t r);
    if (p_args_left != 0) begin
      if (p_body_left < HdrBytes) halt_with(r, ST_MALFORMED);
      else p_phase = PH_ARGLEN;
    end else if (p_body_left == 0) begin
      r.msg_done = 1'b1;
      p_phase = PH_LEN;
    end else begin
      halt_with(r, ST_MALFORMED);
    end
  endfunction

  function automatic result_t parse_stream_byte(input in_item_t w);
    result_t     r;
    logic [31:0] v;
    r = '0;
    if (w.kind == KIND_RESTART) begin
      clear_parse_state();
      return r;
    end
    case (p_phase)
      PH_LEN: begin
        if (shift_header(w.data, v)) begin
          if (v > lim_msg_len) halt_with(r, ST_TOO_LONG);
          else if (v < HdrBytes) halt_with(r, ST_MALFORMED);
          else begin
            p_body_left = v;
            p_arg_total = '0;
            p_args_left = '0;
            p_arg_idx   = '0;
            p_phase     = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        p_body_left = p_body_left - 32'd1;
        if (shift_header(w.data, v)) begin
          if (v > {16'd0, lim_arg_cnt}) halt_with(r, ST_MALFORMED);
          else begin
            p_arg_total   = v[15:0];
            p_args_left   = v[15:0];
            p_arg_idx     = '0;
            r.count_ready = 1'b1;
            close_item(r);
          end
        end
      end
      PH_ARGLEN: begin
        p_body_left = p_body_left - 32'd1;
        if (shift_header(w.data, v)) begin
          if (v > p_body_left) halt_with(r, ST_MALFORMED);
          else begin
            r.arg_start  = 1'b1;
            r.arg_index  = p_arg_idx;
            r.arg_length = v;
            p_args_left  = p_args_left - 16'd1;
            if (v == 0) begin
              p_arg_idx = p_arg_idx + 16'd1;
              close_item(r);
            end else begin
              p_arg_left = v;
              p_phase    = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte  = w.data;
        r.arg_index  = p_arg_idx;
        p_body_left  = p_body_left - 32'd1;
        p_arg_left   = p_arg_left - 32'd1;
        if (p_arg_left == 0) begin
          r.arg_last_byte = 1'b1;
          p_arg_idx = p_arg_idx + 16'd1;
          close_item(r);
        end
      end
      default: begin
        p_phase  = PH_HALT;
        r.status = ST_HALTED;
      end
    endcase
    if (r.status == ST_OK) r.arg_count = p_arg_total;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string what);
    $display("result word %0d: %s", results_seen, what);
    error_count++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (parsed_due.size() == 0) begin
      note_mismatch("result word with nothing pending");
    end else begin
      want = parsed_due.pop_front();
      cmp_field("data_valid", 32'(data_valid_o), 32'(want.data_valid));
      cmp_field("data_byte", 32'(data_byte_o), 32'(want.data_byte));
      cmp_field("arg_index", 32'(arg_index_o), 32'(want.arg_index));
      cmp_field("arg_start", 32'(arg_start_o), 32'(want.arg_start));
      cmp_field("arg_length", arg_length_o, want.arg_length);
      cmp_field("arg_last_byte", 32'(arg_last_byte_o), 32'(want.arg_last_byte));
      cmp_field("count_ready", 32'(count_ready_o), 32'(want.count_ready));
      cmp_field("arg_count", 32'(arg_count_o), 32'(want.arg_count));
      cmp_field("msg_done", 32'(msg_done_o), 32'(want.msg_done));
      cmp_field("status", 32'(status_o), 32'(want.status));
    end
    results_seen++;
  endtask

  // sender: one word in flight, held until the block takes it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push             <= 1'b0;
      stream_byte_i    <= '0;
      new_connection_i <= 1'b0;
    end else begin
      if (push && !full) begin
        parsed_due = {parsed_due, parse_stream_byte(cur_word)};
        send_wait = send_steady ? 0 : idle_len();
        if ($urandom_range(39) == 0) send_steady = !send_steady;
      end
      if (!push || !full) begin
        if (send_wait > 0) begin
          send_wait--;
          push <= 1'b0;
        end else if (stream_words.size() != 0) begin
          cur_word = stream_words.pop_front();
          push             <= 1'b1;
          stream_byte_i    <= cur_word.data;
          new_connection_i <= (cur_word.kind == KIND_RESTART);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_result();
        recv_wait = recv_steady ? 0 : idle_len();
        if ($urandom_range(39) == 0) recv_steady = !recv_steady;
      end
      if (reader_hold) begin
        pop <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // long reader stall so both queues fill and full rises
  initial begin
    while (results_seen < 80) @(negedge clk_i);
    @(posedge clk_i);
    reader_hold <= 1'b1;
    repeat (120) @(posedge clk_i);
    reader_hold <= 1'b0;
  end

  task automatic put_word(input logic [31:0] v);
    for (int k = 0; k < 4; k++) msg_bytes = {msg_bytes, v[8*k +: 8]};
  endtask

  task automatic flush_message(input int keep);
    in_item_t w;
    w.kind = KIND_DATA;
    for (int k = 0; k < keep; k++) begin
      w.data = msg_bytes[k];
      stream_words = {stream_words, w};
    end
    stim_count += keep;
    msg_bytes.delete();
  endtask

  task automatic send_restart();
    in_item_t w;
    w.kind = KIND_RESTART;
    w.data = 8'($urandom_range(255));
    stream_words = {stream_words, w};
    stim_count++;
  endtask

  task automatic queue_message(input msg_shape_e shape);
    int          n;
    int          bad;
    int          keep;
    int          lens[$];
    logic [31:0] body;
    logic [31:0] len_field;
    logic [31:0] cnt_field;
    logic [31:0] arg_field;
    msg_bytes.delete();
    n = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
    if (n > lim_arg_cnt) n = lim_arg_cnt;
    body = 32'd4;
    for (int i = 0; i < n; i++) begin
      lens = {lens, int'(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6))};
      body = body + 32'd4 + 32'(lens[i]);
    end
    len_field = body;
    cnt_field = 32'(n);
    bad = (n > 0) ? $urandom_range(n - 1) : 0;
    case (shape)
      SHAPE_TOO_LONG:
        if (lim_msg_len != '1) len_field = lim_msg_len + 32'd1 + 32'($urandom_range(50));
      SHAPE_SHORT_BODY:     len_field = 32'($urandom_range(3));
      SHAPE_TOO_MANY_ARGS:  cnt_field = 32'(lim_arg_cnt) + 32'd1 + 32'($urandom_range(3));
      SHAPE_TRUNCATED_BODY: if (body > 4) len_field = body - 32'($urandom_range(1, body - 4));
      SHAPE_PADDED_BODY:    len_field = body + 32'($urandom_range(1, 6));
      default: ;
    endcase
    put_word(len_field);
    put_word(cnt_field);
    for (int i = 0; i < n; i++) begin
      arg_field = 32'(lens[i]);
      if (shape == SHAPE_OVERSIZE_ARG && i == bad)
        arg_field = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : body + 32'($urandom_range(1, 99));
      put_word(arg_field);
      repeat (lens[i]) msg_bytes = {msg_bytes, 8'($urandom_range(255))};
    end
    keep = msg_bytes.size();
    // headers that fail early: the rest of the body would only hit a halted parser
    if (shape == SHAPE_CUT_SHORT) keep = $urandom_range(keep - 1);
    else if (shape == SHAPE_TOO_LONG || shape == SHAPE_SHORT_BODY) keep = 4 + $urandom_range(3);
    else if (shape == SHAPE_TOO_MANY_ARGS) keep = 8 + $urandom_range(2);
    if (keep > msg_bytes.size()) keep = msg_bytes.size();
    flush_message(keep);
    if (shape != SHAPE_GOOD || body > lim_msg_len || $urandom_range(11) == 0) begin
      repeat ($urandom_range(2)) msg_bytes = {msg_bytes, 8'($urandom_range(255))};
      flush_message(msg_bytes.size());
      send_restart();
    end
  endtask

  task automatic run_random(input int n_words);
    int target;
    target = stim_count + n_words;
    while (stim_count < target) begin
      if ($urandom_range(9) < 7) queue_message(SHAPE_GOOD);
      else queue_message(msg_shape_e'($urandom_range(int'(SHAPE_TOO_LONG),
                                                     int'(SHAPE_CUT_SHORT))));
    end
  endtask

  task automatic wait_drained();
    while (stream_words.size() != 0 || push || parsed_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CfgMaxMsgLen) lim_msg_len = val;
    else if (idx == CfgMaxArgCount) lim_arg_cnt = val[15:0];
  endtask

  task automatic set_limits(input logic [31:0] msg_len, input logic [15:0] arg_cnt);
    wait_drained();
    write_limit(CfgUnusedA, $urandom);
    write_limit(CfgMaxMsgLen, msg_len);
    // upper bits of the count register are dropped
    write_limit(CfgMaxArgCount, {16'($urandom), arg_cnt});
    write_limit(CfgUnusedB, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    lim_msg_len = MaxMsgLenReset;
    lim_arg_cnt = MaxArgCountReset;
    clear_parse_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero-length argument then a one-byte argument
    put_word(32'd13);
    put_word(32'd2);
    put_word(32'd0);
    put_word(32'd1);
    msg_bytes = {msg_bytes, 8'hFF};
    flush_message(msg_bytes.size());
    // oversized body, then a word into the halted parser
    put_word(32'hFFFF_FFFF);
    msg_bytes = {msg_bytes, 8'h5A};
    flush_message(msg_bytes.size());
    send_restart();
    // body too short to hold the count
    put_word(32'd3);
    flush_message(msg_bytes.size());
    send_restart();

    run_random(90);
    set_limits(32'hFFFF_FFFF, 16'hFFFF);
    run_random(45);
    wait_drained();
    run_random(45);
    set_limits(32'd40, 16'd3);
    run_random(80);
    set_limits(32'd0, 16'd0);
    run_random(20);
    set_limits(32'd4, 16'd0);
    run_random(20);
    set_limits(32'($urandom_range(30, 300)), 16'($urandom_range(1, 8)));
    run_random(100);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
